/* rtl/core/isir_pkg.sv */
// ----------------------------------------------------------------------------
// isir_pkg
// Shared codes, field widths and controller/datapath interface types for the
// indexed sequence insert/remove block.
// ----------------------------------------------------------------------------
package isir_pkg;

    localparam int ISIR_CAPACITY = 32;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int OUT_COUNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec_op;     // Execute the accepted item and load its single result.
        logic dump_start;  // Clear the dump index.
        logic dump_emit;   // Load the entry at the dump index as a result.
    } isir_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;   // Output register holds a result.
        logic count_zero;  // Sequence is empty.
        logic dump_last;   // Dump index points at the final entry.
    } isir_stat_t;

endpackage

/* rtl/core/isir_ctrl.sv */
// ----------------------------------------------------------------------------
// isir_ctrl
// Controller: accepts items and sequences the entries of a dump.
// ----------------------------------------------------------------------------
module isir_ctrl
    import isir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_is_dump,
    input  logic       out_ready,
    input  isir_stat_t stat,
    output logic       in_ready,
    output isir_cmd_t  cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   slot_free;
    logic   accept;

    // The output register can take a result when empty or being drained.
    assign slot_free = !stat.out_valid || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.exec_op    = 1'b0;
        cmd.dump_start = 1'b0;
        cmd.dump_emit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_is_dump && !stat.count_zero)
                    begin
                        cmd.dump_start = 1'b1;
                        state_next     = S_DUMP;
                    end
                    else
                    begin
                        cmd.exec_op = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    cmd.dump_emit = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/isir_dpath.sv */
// ----------------------------------------------------------------------------
// isir_dpath
// Datapath: entry register array with parallel shift, entry count, dump
// index and the output result register.
// ----------------------------------------------------------------------------
module isir_dpath
    import isir_pkg::*;
#(
    parameter int CAPACITY = ISIR_CAPACITY
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  isir_cmd_t              cmd,
    input  logic [CMD_W-1:0]       in_cmd,
    input  logic [POS_W-1:0]       in_position,
    input  logic [VALUE_W-1:0]     in_value,
    input  logic                   out_ready,
    output isir_stat_t             stat,
    output logic                   out_valid,
    output logic [STATUS_W-1:0]    out_status,
    output logic [VALUE_W-1:0]     out_element,
    output logic                   out_has_element,
    output logic [OUT_COUNT_W-1:0] out_count,
    output logic                   out_is_empty,
    output logic                   out_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [VALUE_W-1:0]     entries_reg [CAPACITY];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [STATUS_W-1:0]    op_status;
    logic                   do_insert;
    logic                   do_remove;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [VALUE_W-1:0]     out_element_reg;
    logic                   out_has_element_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic                   out_is_empty_reg;
    logic                   out_last_reg;

    assign pos_ext = CMP_W'(in_position);
    assign cnt_ext = CMP_W'(count_reg);

    // Decode the accepted item and check its position against the count.
    always_comb
    begin
        op_status  = ST_OK;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        count_next = count_reg;
        case (in_cmd)
            CMD_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    op_status = ST_RANGE;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    op_status = ST_FULL;
                end
                else
                begin
                    do_insert  = cmd.exec_op;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    op_status = ST_RANGE;
                end
                else
                begin
                    do_remove  = cmd.exec_op;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                op_status = ST_OK;
            end
        endcase
    end

    // Each entry above the position takes its lower neighbor on insert, and
    // each entry at or above it takes its upper one on remove; entries above the count hold don't-care data.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_entry
        logic above_pos;
        logic at_pos;

        assign above_pos = CMP_W'(g) > pos_ext;
        assign at_pos    = CMP_W'(g) == pos_ext;

        always_ff @(posedge clk)
        begin
            if (do_insert && at_pos)
            begin
                entries_reg[g] <= in_value;
            end
            else if (do_insert && above_pos)
            begin
                if (g > 0)
                begin
                    entries_reg[g] <= entries_reg[(g > 0) ? g - 1 : 0];
                end
            end
            else if (do_remove && (above_pos || at_pos))
            begin
                if (g < CAPACITY - 1)
                begin
                    entries_reg[g] <= entries_reg[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    end

    assign stat.out_valid  = out_valid_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.dump_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec_op)
            begin
                count_reg <= count_next;
            end
            if (cmd.dump_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.dump_emit)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.exec_op || cmd.dump_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_op)
        begin
            out_status_reg      <= op_status;
            out_element_reg     <= '0;
            out_has_element_reg <= 1'b0;
            out_count_reg       <= OUT_COUNT_W'(count_next);
            out_is_empty_reg    <= (count_next == '0);
            out_last_reg        <= 1'b1;
        end
        else if (cmd.dump_emit)
        begin
            out_status_reg      <= ST_OK;
            out_element_reg     <= entries_reg[idx_reg];
            out_has_element_reg <= 1'b1;
            out_count_reg       <= OUT_COUNT_W'(count_reg);
            out_is_empty_reg    <= 1'b0;
            out_last_reg        <= stat.dump_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_element     = out_element_reg;
    assign out_has_element = out_has_element_reg;
    assign out_count       = out_count_reg;
    assign out_is_empty    = out_is_empty_reg;
    assign out_last        = out_last_reg;

endmodule

/* rtl/core/indexed_sequence_insert_remove.sv */
// ----------------------------------------------------------------------------
// indexed_sequence_insert_remove
// Ordered store of signed 32-bit values with insert and remove at a position
// and a dump of all entries.
// ----------------------------------------------------------------------------
// Results: an insert or remove result is registered in the cycle after
// the item is accepted; a dump of N entries then gives one entry per
// cycle while the output is taken. Throughput: one insert or remove per
// cycle while the output is taken; a dump holds off the input until its
// last entry is out, paced by the single read port on the entry array.
// Reset clears the count, the controller and the output valid; entry
// contents are not reset and are read only after being written.
// ----------------------------------------------------------------------------
module indexed_sequence_insert_remove
    import isir_pkg::*;
#(
    parameter int CAPACITY = ISIR_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[1:0], position[7:2], value[39:8]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[1:0], element[33:2], count[39:34],
                                   // is_empty[40], zero fill[47:41]
    output logic        m_tuser,   // has_element
    output logic        m_tlast
);

    logic [CMD_W-1:0]       in_cmd;
    logic [POS_W-1:0]       in_position;
    logic [VALUE_W-1:0]     in_value;
    isir_cmd_t              cmd;
    isir_stat_t             stat;
    logic [STATUS_W-1:0]    out_status;
    logic [VALUE_W-1:0]     out_element;
    logic                   out_has_element;
    logic [OUT_COUNT_W-1:0] out_count;
    logic                   out_is_empty;

    // Unpack the input item fields.
    assign in_cmd      = s_tdata[1:0];
    assign in_position = s_tdata[7:2];
    assign in_value    = s_tdata[39:8];

    // The controller decides when an item is taken and walks the dump; the
    // datapath does the shifting, counting and result formatting.
    isir_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_is_dump (in_cmd == CMD_DUMP),
        .out_ready  (m_tready),
        .stat       (stat),
        .in_ready   (s_tready),
        .cmd        (cmd)
    );

    isir_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_cmd          (in_cmd),
        .in_position     (in_position),
        .in_value        (in_value),
        .out_ready       (m_tready),
        .stat            (stat),
        .out_valid       (m_tvalid),
        .out_status      (out_status),
        .out_element     (out_element),
        .out_has_element (out_has_element),
        .out_count       (out_count),
        .out_is_empty    (out_is_empty),
        .out_last        (m_tlast)
    );

    // Pack the result fields from the lowest bit up.
    assign m_tdata = {7'd0, out_is_empty, out_count, out_element, out_status};
    assign m_tuser = out_has_element;

    // A result without an element is always the only result of its item.
    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("result without element is not marked last");

    // A dumped entry can only come from a non-empty sequence.
    a_dump_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tdata[40])
        else $error("dumped entry reported with empty sequence");

    // Any accepted item other than a dump loads its result at once.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tdata[1:0] != CMD_DUMP)) |=> m_tvalid)
        else $error("insert or remove result missing");

    // The input is held off while a dump is being walked.
    a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_start |=> !s_tready)
        else $error("input accepted during dump");

endmodule
